>>> sv/kcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kcf_pkg;

  localparam int NUM_WORDS = 16;
  localparam int MAX_LEN   = 16;
  localparam int IDX_W     = $clog2(NUM_WORDS);
  localparam int POS_W     = $clog2(MAX_LEN);
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int CMDQ_DEPTH = 4;

  localparam logic [7:0] MASK_CHAR = 8'h2A;

  localparam logic [2:0] MODE_LOAD  = 3'd0;
  localparam logic [2:0] MODE_TEXT  = 3'd1;
  localparam logic [2:0] MODE_EOL   = 3'd2;
  localparam logic [2:0] MODE_READ  = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_EOL   = 2'd1;
  localparam logic [1:0] KIND_COUNT = 2'd2;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_TEXT,
    OP_EOL,
    OP_READ,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] word_index;
    logic [3:0] char_pos;
    logic [7:0] char_value;
    logic       last_char;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_char;
    logic [15:0] match_count;
    logic        last;
  } res_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/keyword_censor_filter_top.sv
// Items wait in the command queue; each result beat is registered in the output queue.
// A text byte leaves when MAX_LEN later text items have entered, or on end of line.
// Throughput: one item per cycle unless the output queue is full or end of line drains.
// The rate is set by the single engine that consumes the four-entry command queue.
// Reset clears queues, window, keyword lengths, holdoffs and counts; keyword bytes are kept.
`timescale 1ns / 1ps
`default_nettype none

module keyword_censor_filter_top import kcf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  mode_i,
  input  wire logic [3:0]  word_index_i,
  input  wire logic [3:0]  char_pos_i,
  input  wire logic [7:0]  char_value_i,
  input  wire logic        last_char_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind_o,
  output logic [7:0]       out_char_o,
  output logic [15:0]      match_count_o,
  output logic             last_o
);

  logic cmd_valid, cmd_ready, res_valid, res_ready;
  cmd_t cmd;
  res_t res, res_out;

  kcf_front u_front (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .full_o       (full),
    .mode_i,
    .word_index_i,
    .char_pos_i,
    .char_value_i,
    .last_char_i,
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  kcf_back u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  kcf_out_q u_out_q (
    .clk_i,
    .rst_ni,
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res_out)
  );

  assign kind_o        = res_out.kind;
  assign out_char_o    = res_out.out_char;
  assign match_count_o = res_out.match_count;
  assign last_o        = res_out.last;

endmodule

`default_nettype wire

>>> sv/kcf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module kcf_front import kcf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  output logic            full_o,
  input  wire logic [2:0] mode_i,
  input  wire logic [3:0] word_index_i,
  input  wire logic [3:0] char_pos_i,
  input  wire logic [7:0] char_value_i,
  input  wire logic       last_char_i,
  output logic            cmd_valid_o,
  input  wire logic       cmd_ready_i,
  output cmd_t            cmd_o
);

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             mem_q [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  cmd_t             dec;
  logic             dec_ok;
  logic             wr_en, rd_en;

  always_comb begin
    dec.word_index = word_index_i;
    dec.char_pos   = char_pos_i;
    dec.char_value = char_value_i;
    dec.last_char  = last_char_i;
    dec.op         = OP_LOAD;
    dec_ok         = 1'b1;
    unique case (mode_i)
      MODE_LOAD:  dec.op = OP_LOAD;
      MODE_TEXT:  dec.op = OP_TEXT;
      MODE_EOL:   dec.op = OP_EOL;
      MODE_READ:  dec.op = OP_READ;
      MODE_CLEAR: dec.op = OP_CLEAR;
      default:    dec_ok = 1'b0;
    endcase
  end

  assign full_o      = (cnt_q == CNT_W'(CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];
  assign wr_en       = push_i && !full_o && dec_ok;
  assign rd_en       = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_d  = wr_en ? wr_q + PTR_W'(1) : wr_q;
    rd_d  = rd_en ? rd_q + PTR_W'(1) : rd_q;
    cnt_d = cnt_q + CNT_W'(wr_en) - CNT_W'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= dec;
    end
  end

endmodule

`default_nettype wire

>>> sv/kcf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module kcf_back import kcf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  output logic      cmd_ready_o,
  input  wire cmd_t cmd_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output res_t      res_o
);

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic             state_q, state_d;
  logic [7:0]       hist_q [MAX_LEN];
  logic             mask_q [MAX_LEN];
  logic [LEN_W-1:0] fill_q;
  logic [7:0]       kw_q   [NUM_WORDS][MAX_LEN];
  logic [LEN_W-1:0] len_q  [NUM_WORDS];
  logic [POS_W-1:0] hold_q [NUM_WORDS];
  logic [15:0]      cnt_q  [NUM_WORDS];

  logic [7:0]       sh_hist [MAX_LEN];
  logic [7:0]       sh_fold [MAX_LEN];
  logic             sh_mask [MAX_LEN];
  logic             hmask   [MAX_LEN];
  logic             hit     [NUM_WORDS];
  logic [LEN_W-1:0] fill_n;
  logic             win_full;
  logic [POS_W-1:0] tail;
  logic             take;
  logic             do_text;

  assign win_full    = (fill_q == LEN_W'(MAX_LEN));
  assign tail        = POS_W'(fill_q - LEN_W'(1));
  assign cmd_ready_o = (state_q == ST_RUN) && res_ready_i;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign do_text     = take && (cmd_i.op == OP_TEXT);
  assign fill_n      = win_full ? fill_q : fill_q + LEN_W'(1);

  always_comb begin
    for (int j = 0; j < MAX_LEN; j++) begin
      sh_hist[j] = (j == 0) ? cmd_i.char_value : hist_q[(j == 0) ? 0 : j - 1];
      sh_mask[j] = (j == 0) ? 1'b0 : mask_q[(j == 0) ? 0 : j - 1];
      sh_fold[j] = fold(sh_hist[j]);
    end
    for (int w = 0; w < NUM_WORDS; w++) begin
      hit[w] = (hold_q[w] == '0) && (len_q[w] != '0) && (len_q[w] <= fill_n);
      for (int p = 0; p < MAX_LEN; p++) begin
        if (LEN_W'(p) < len_q[w]) begin
          if (kw_q[w][p] != sh_fold[POS_W'(len_q[w] - LEN_W'(p) - LEN_W'(1))]) begin
            hit[w] = 1'b0;
          end
        end
      end
    end
    for (int j = 0; j < MAX_LEN; j++) begin
      hmask[j] = 1'b0;
      for (int w = 0; w < NUM_WORDS; w++) begin
        if (hit[w] && (LEN_W'(j) < len_q[w])) begin
          hmask[j] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_d           = state_q;
    res_valid_o       = 1'b0;
    res_o.kind        = KIND_CHAR;
    res_o.out_char    = '0;
    res_o.match_count = '0;
    res_o.last        = 1'b1;
    unique case (state_q)
      ST_RUN: begin
        if (cmd_valid_i && cmd_i.op == OP_TEXT && win_full) begin
          res_valid_o    = 1'b1;
          res_o.out_char = mask_q[MAX_LEN-1] ? MASK_CHAR : hist_q[MAX_LEN-1];
        end else if (cmd_valid_i && cmd_i.op == OP_READ) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_COUNT;
          if ({1'b0, cmd_i.word_index} < 5'(NUM_WORDS)) begin
            res_o.match_count = cnt_q[IDX_W'(cmd_i.word_index)];
          end
        end
        if (take && cmd_i.op == OP_EOL) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        res_valid_o = 1'b1;
        if (fill_q != '0) begin
          res_o.out_char = mask_q[tail] ? MASK_CHAR : hist_q[tail];
          res_o.last     = 1'b0;
        end else begin
          res_o.kind = KIND_EOL;
          if (res_ready_i) begin
            state_d = ST_RUN;
          end
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      fill_q  <= '0;
      for (int j = 0; j < MAX_LEN; j++) begin
        mask_q[j] <= 1'b0;
        hist_q[j] <= '0;
      end
      for (int w = 0; w < NUM_WORDS; w++) begin
        len_q[w]  <= '0;
        hold_q[w] <= '0;
        cnt_q[w]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (do_text) begin
        fill_q <= fill_n;
        for (int j = 0; j < MAX_LEN; j++) begin
          hist_q[j] <= sh_hist[j];
          mask_q[j] <= sh_mask[j] | hmask[j];
        end
        for (int w = 0; w < NUM_WORDS; w++) begin
          if (hold_q[w] != '0) begin
            hold_q[w] <= hold_q[w] - POS_W'(1);
          end else if (hit[w]) begin
            hold_q[w] <= POS_W'(len_q[w] - LEN_W'(1));
            if (cnt_q[w] != 16'hFFFF) begin
              cnt_q[w] <= cnt_q[w] + 16'd1;
            end
          end
        end
      end
      if (take && cmd_i.op == OP_LOAD && cmd_i.last_char &&
          {1'b0, cmd_i.word_index} < 5'(NUM_WORDS) &&
          {1'b0, cmd_i.char_pos} < 5'(MAX_LEN)) begin
        len_q[IDX_W'(cmd_i.word_index)]  <= LEN_W'(cmd_i.char_pos) + LEN_W'(1);
        hold_q[IDX_W'(cmd_i.word_index)] <= '0;
      end
      if (take && cmd_i.op == OP_CLEAR) begin
        for (int w = 0; w < NUM_WORDS; w++) begin
          cnt_q[w] <= '0;
        end
      end
      if (state_q == ST_FLUSH && res_ready_i) begin
        if (fill_q != '0) begin
          fill_q <= fill_q - LEN_W'(1);
        end else begin
          for (int w = 0; w < NUM_WORDS; w++) begin
            hold_q[w] <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && cmd_i.op == OP_LOAD &&
        {1'b0, cmd_i.word_index} < 5'(NUM_WORDS) &&
        {1'b0, cmd_i.char_pos} < 5'(MAX_LEN)) begin
      kw_q[IDX_W'(cmd_i.word_index)][POS_W'(cmd_i.char_pos)] <= fold(cmd_i.char_value);
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LEN_W'(MAX_LEN))
    else $error("window fill above capacity");

  a_flush_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && res_ready_i && fill_q != '0) |=>
      fill_q == $past(fill_q) - LEN_W'(1))
    else $error("flush did not drain one byte");

  a_eol_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i && res_o.kind == KIND_EOL) |=>
      (fill_q == '0 && state_q == ST_RUN))
    else $error("end marker left window not empty");

endmodule

`default_nettype wire

>>> sv/kcf_out_q.sv
`timescale 1ns / 1ps
`default_nettype none

module kcf_out_q import kcf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_valid_i,
  output logic      res_ready_o,
  input  wire res_t res_i,
  output logic      empty_o,
  input  wire logic pop_i,
  output res_t      res_o
);

  res_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign res_ready_o = (cnt_q != 2'd2);
  assign empty_o     = (cnt_q == 2'd0);
  assign res_o       = mem_q[rd_q];
  assign wr_en       = res_valid_i && res_ready_o;
  assign rd_en       = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wr_q <= ~wr_q;
      end
      if (rd_en) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_keyword_censor_filter_top.sv
`timescale 1ns / 1ps

module tb_keyword_censor_filter_top;
  import kcf_pkg::*;

  localparam logic [2:0] MODE_RSVD_LO = 3'd5;
  localparam logic [2:0] MODE_RSVD_HI = 3'd7;

  typedef struct {
    logic [2:0] mode;
    logic [3:0] wi;
    logic [3:0] pos;
    logic [7:0] cv;
    logic       lc;
    bit         pause;
  } cmd_beat_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [15:0] cnt;
    logic        last;
  } out_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [2:0]  mode_i = '0;
  logic [3:0]  word_index_i = '0;
  logic [3:0]  char_pos_i = '0;
  logic [7:0]  char_value_i = '0;
  logic        last_char_i = 1'b0;
  logic        full;
  logic        empty;
  logic [1:0]  kind_o;
  logic [7:0]  out_char_o;
  logic [15:0] match_count_o;
  logic        last_o;

  keyword_censor_filter_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .mode_i(mode_i), .word_index_i(word_index_i), .char_pos_i(char_pos_i),
    .char_value_i(char_value_i), .last_char_i(last_char_i),
    .empty(empty), .pop(pop), .kind_o(kind_o), .out_char_o(out_char_o),
    .match_count_o(match_count_o), .last_o(last_o)
  );

  cmd_beat_t pending_cmds[$];
  out_beat_t expected_out[$];
  int errors = 0;
  int cyc = 0;
  int settle = 0;
  bit written[NUM_WORDS][MAX_LEN];

  logic [7:0]  kw_chars[NUM_WORDS][MAX_LEN];
  logic [4:0]  kw_len[NUM_WORDS];
  logic [3:0]  holdoff[NUM_WORDS];
  logic [7:0]  win_chars[MAX_LEN];
  bit          win_mask[MAX_LEN];
  int          win_fill;
  logic [15:0] counts[NUM_WORDS];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] lower_ascii(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic logic [7:0] kw_chars_seed(int w);
    return 8'h61 + {6'd0, w[1:0]};
  endfunction

  function automatic void add_out(logic [1:0] k, logic [7:0] c, logic [15:0] n, logic l);
    out_beat_t o;
    o.kind = k;
    o.ch = c;
    o.cnt = n;
    o.last = l;
    expected_out = {expected_out, o};
  endfunction

  function automatic void match_keywords();
    int len;
    bit hit;
    for (int w = 0; w < NUM_WORDS; w++) begin
      len = int'(kw_len[w]);
      if (holdoff[w] != 0) begin
        holdoff[w]--;
        continue;
      end
      if (len == 0 || len > win_fill) continue;
      hit = 1;
      for (int p = 0; p < len; p++) begin
        if (lower_ascii(win_chars[win_fill - len + p]) != lower_ascii(kw_chars[w][p])) begin
          hit = 0;
        end
      end
      if (!hit) continue;
      if (counts[w] != 16'hFFFF) counts[w]++;
      for (int p = win_fill - len; p < win_fill; p++) win_mask[p] = 1;
      holdoff[w] = 4'(len - 1);
    end
  endfunction

  function automatic void predict_censor(cmd_beat_t c);
    case (c.mode)
      MODE_LOAD: begin
        kw_chars[c.wi][c.pos] = c.cv;
        if (c.lc) begin
          kw_len[c.wi] = {1'b0, c.pos} + 5'd1;
          holdoff[c.wi] = '0;
        end
      end
      MODE_TEXT: begin
        if (win_fill >= MAX_LEN) begin
          add_out(KIND_CHAR, win_mask[0] ? MASK_CHAR : win_chars[0], 16'd0, 1'b1);
          for (int i = 0; i < MAX_LEN - 1; i++) begin
            win_chars[i] = win_chars[i + 1];
            win_mask[i] = win_mask[i + 1];
          end
          win_fill = MAX_LEN - 1;
        end
        win_chars[win_fill] = c.cv;
        win_mask[win_fill] = 0;
        win_fill++;
        match_keywords();
      end
      MODE_EOL: begin
        for (int i = 0; i < win_fill; i++) begin
          add_out(KIND_CHAR, win_mask[i] ? MASK_CHAR : win_chars[i], 16'd0, 1'b0);
        end
        add_out(KIND_EOL, 8'd0, 16'd0, 1'b1);
        for (int i = 0; i < MAX_LEN; i++) begin
          win_chars[i] = '0;
          win_mask[i] = 0;
        end
        for (int w = 0; w < NUM_WORDS; w++) holdoff[w] = '0;
        win_fill = 0;
      end
      MODE_READ: add_out(KIND_COUNT, 8'd0, counts[c.wi], 1'b1);
      MODE_CLEAR: begin
        for (int w = 0; w < NUM_WORDS; w++) counts[w] = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic put(logic [2:0] m, logic [3:0] wi, logic [3:0] pos, logic [7:0] cv, logic lc);
    cmd_beat_t c;
    c.mode = m;
    c.wi = wi;
    c.pos = pos;
    c.cv = cv;
    c.lc = lc;
    c.pause = 0;
    if (m == MODE_LOAD) written[wi][pos] = 1;
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic load_word(int slot, string s);
    for (int i = 0; i < s.len(); i++) begin
      put(MODE_LOAD, 4'(slot), 4'(i), s[i], i == s.len() - 1);
    end
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      put(MODE_TEXT, 4'($urandom), 4'($urandom), s[i], 1'($urandom));
    end
  endtask

  function automatic string random_word(int n);
    string alpha = "aAbB";
    string s = "";
    for (int i = 0; i < n; i++) s = {s, string'(alpha[$urandom_range(3)])};
    return s;
  endfunction

  function automatic bit idle_now();
    return (cyc % 1000 >= 300) && ($urandom_range(99) < 15);
  endfunction

  always @(posedge clk_i) cyc <= cyc + 1;

  // Command driver.
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_beat_t c;
    logic nxt;
    if (!rst_ni) begin
      push <= 1'b0;
      settle = 0;
    end else begin
      nxt = push;
      if (push && !full) begin
        c.mode = mode_i;
        c.wi = word_index_i;
        c.pos = char_pos_i;
        c.cv = char_value_i;
        c.lc = last_char_i;
        predict_censor(c);
        nxt = 1'b0;
      end
      if (!nxt && pending_cmds.size() > 0 && pending_cmds[0].pause) begin
        settle = expected_out.size() == 0 ? settle + 1 : 0;
        if (settle > 4) begin
          void'(pending_cmds.pop_front());
          settle = 0;
        end
      end else if (!nxt && pending_cmds.size() > 0 && !idle_now()) begin
        c = pending_cmds.pop_front();
        mode_i <= c.mode;
        word_index_i <= c.wi;
        char_pos_i <= c.pos;
        char_value_i <= c.cv;
        last_char_i <= c.lc;
        nxt = 1'b1;
      end
      push <= nxt;
    end
  end

  // Result monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t e;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_out.size() == 0) begin
          $error("unexpected result beat kind=%0d char=%h", kind_o, out_char_o);
          errors++;
        end else begin
          e = expected_out.pop_front();
          if (kind_o !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, kind_o);
            errors++;
          end
          if (out_char_o !== e.ch) begin
            $error("out_char: expected %h, got %h", e.ch, out_char_o);
            errors++;
          end
          if (match_count_o !== e.cnt) begin
            $error("match_count: expected %0d, got %0d", e.cnt, match_count_o);
            errors++;
          end
          if (last_o !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, last_o);
            errors++;
          end
        end
      end
      pop <= !idle_now();
    end
  end

  initial begin
    cmd_beat_t hold;
    int r;
    int n;
    string s;
    win_fill = 0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      kw_len[w] = '0;
      holdoff[w] = '0;
      counts[w] = '0;
      for (int p = 0; p < MAX_LEN; p++) kw_chars[w][p] = '0;
    end
    for (int i = 0; i < MAX_LEN; i++) begin
      win_chars[i] = '0;
      win_mask[i] = 0;
    end

    // Directed part: mixed case, overlapping repeats, a full-length keyword with extreme bytes.
    load_word(0, "Ab");
    load_word(1, "aa");
    load_word(2, "Z");
    s = "";
    for (int i = 0; i < MAX_LEN; i++) s = {s, string'((i % 2) ? 8'hFF : 8'h80)};
    load_word(15, s);
    put_text("xaBaaaazZ@[`{");
    put(MODE_TEXT, 4'd0, 4'd0, 8'h00, 1'b0);
    put_text(s);
    put_text("ab");
    put(MODE_EOL, 4'd0, 4'd0, 8'd0, 1'b0);
    put(MODE_READ, 4'd0, 4'd0, 8'd0, 1'b0);
    put(MODE_READ, 4'd1, 4'd0, 8'd0, 1'b0);
    put(MODE_READ, 4'd15, 4'd0, 8'd0, 1'b0);
    put(MODE_RSVD_LO, 4'hF, 4'hF, 8'hFF, 1'b1);
    put(MODE_RSVD_HI, 4'd0, 4'd0, 8'd0, 1'b0);
    put(MODE_CLEAR, 4'd0, 4'd0, 8'd0, 1'b0);
    put(MODE_READ, 4'd1, 4'd0, 8'd0, 1'b0);

    for (int i = 0; i < 150; i++) begin
      if (i == 75) begin
        hold.pause = 1;
        pending_cmds = {pending_cmds, hold};
      end
      r = $urandom_range(99);
      if (r < 6) begin
        load_word($urandom_range(NUM_WORDS - 1), random_word($urandom_range(1, 4)));
      end else if (r < 10) begin
        n = $urandom_range(NUM_WORDS - 1);
        r = $urandom_range(MAX_LEN - 1);
        put(MODE_LOAD, 4'(n), 4'(r), 8'($urandom), 1'b0);
      end else if (r < 68) begin
        put_text(random_word(1));
      end else if (r < 76) begin
        put(MODE_TEXT, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
      end else if (r < 86) begin
        put(MODE_EOL, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
      end else if (r < 94) begin
        put(MODE_READ, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
      end else if (r < 96) begin
        put(MODE_CLEAR, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        put(3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI)), 4'($urandom), 4'($urandom),
            8'($urandom), 1'($urandom));
      end
    end
    // Terminate each slot that has written bytes with a last-char load at the end of its contiguous written prefix.
    for (int w = 0; w < NUM_WORDS; w++) begin
      n = 0;
      while (n < MAX_LEN && written[w][n]) n++;
      if (n > 0) put(MODE_LOAD, 4'(w), 4'(n - 1), kw_chars_seed(w), 1'b1);
    end
    put(MODE_EOL, 4'd0, 4'd0, 8'd0, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(pending_cmds.size() == 0 && !push && expected_out.size() == 0)) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (expected_out.size() != 0) begin
      $error("%0d result beats never arrived", expected_out.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
